/* rtl/sled_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sled_pkg;

    // Request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_SET_MODE   = 2'd1,
        REQ_SET_CUSTOM = 2'd2
    } req_t;

    // LED patterns
    typedef enum logic [2:0] {
        MODE_IDLE          = 3'd0,
        MODE_MOVING        = 3'd1,
        MODE_ERROR         = 3'd2,
        MODE_BRAIN_OFFLINE = 3'd3,
        MODE_LOW_BATTERY   = 3'd4,
        MODE_CUSTOM        = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    localparam int PHASE_BITS_DEF       = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    // Breathing steps per tick, Q0.32 of a full turn
    localparam longint STEP_IDLE_Q32  = 64'd10937045;
    localparam longint STEP_AMBER_Q32 = 64'd20506958;

    // Blink half periods in ms
    localparam logic [31:0] HALF_ERROR_MS   = 32'd250;
    localparam logic [31:0] HALF_BATTERY_MS = 32'd1000;

    // Pattern colors
    localparam color_t COLOR_IDLE    = '{red: 8'd0,   green: 8'd80,  blue: 8'd200};
    localparam color_t COLOR_MOVING  = '{red: 8'd0,   green: 8'd200, blue: 8'd0};
    localparam color_t COLOR_ERROR   = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
    localparam color_t COLOR_AMBER   = '{red: 8'd255, green: 8'd160, blue: 8'd0};
    localparam color_t COLOR_BATTERY = '{red: 8'd255, green: 8'd100, blue: 8'd0};
    localparam color_t COLOR_OFF     = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};

    // Full-scale breathing factor (Q0.8 one)
    localparam logic [8:0] FACTOR_ONE = 9'd256;

    // Sine polynomial coefficients, Q14
    localparam longint SIN_A = 64'd25736;
    localparam longint SIN_B = 64'd10583;
    localparam longint SIN_C = 64'd1306;

    // Q0.32 step rounded half up to a phase of pb bits
    function automatic longint phase_step(input longint q32, input int pb);
        longint half;
        half = 64'd1 << (31 - pb);
        return (q32 + half) >>> (32 - pb);
    endfunction

    // Quarter-wave sine, z and result in Q14
    function automatic longint quarter_sine(input longint z);
        longint z2;
        longint inner;
        longint outer;
        longint s;
        z2    = (z * z) >>> 14;
        inner = SIN_B - ((z2 * SIN_C) >>> 14);
        outer = SIN_A - ((z2 * inner) >>> 14);
        s     = (z * outer) >>> 14;
        if (s > 64'd16384) s = 64'd16384;
        if (s < 64'sd0) s = 64'd0;
        return s;
    endfunction

    // Breathing factor for a table index, Q0.8 in 0..256
    function automatic logic [8:0] breathe_factor(input longint idx, input int idx_bits);
        longint t;
        longint quad;
        longint u;
        longint z;
        longint s;
        longint v;
        t    = ((idx << 16) >> idx_bits) & 64'hFFFF;
        quad = t >> 14;
        u    = t & 64'h3FFF;
        z    = quad[0] ? (64'd16384 - u) : u;
        s    = quarter_sine(z);
        v    = (quad >= 64'd2) ? (64'd16384 - s) : (64'd16384 + s);
        return 9'((v + 64'd64) >> 7);
    endfunction

endpackage

`default_nettype wire

/* rtl/status_led_pattern_generator_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// A tick word is registered in the input register, then loaded into the duty register.
// Throughput: one word per cycle; only a tick is held in the input register,
// and only while the duty register is full and stalled.
// Mode and custom-color words produce no output word.
// Reset (rst_n low, async): idle mode, phase zero, blink off, last toggle
// zero, custom color black, both channels empty.
module status_led_pattern_generator_top
    import sled_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [31:0] now_ms,
    input  wire logic [2:0]  mode,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       duty_red,
    output logic [7:0]       duty_green,
    output logic [7:0]       duty_blue
);

    localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam logic [PHASE_BITS-1:0] STEP_IDLE =
        PHASE_BITS'(phase_step(STEP_IDLE_Q32, PHASE_BITS));
    localparam logic [PHASE_BITS-1:0] STEP_AMBER =
        PHASE_BITS'(phase_step(STEP_AMBER_Q32, PHASE_BITS));

    // Input register
    logic        in_valid_reg;
    logic [1:0]  req_reg;
    logic [31:0] now_reg;
    logic [2:0]  mode_in_reg;
    color_t      color_in_reg;

    // Pattern state
    logic [2:0]            mode_reg,       mode_next;
    logic [PHASE_BITS-1:0] phase_reg,      phase_next;
    logic                  blink_on_reg,   blink_on_next;
    logic [31:0]           last_toggle_reg, last_toggle_next;
    color_t                custom_reg,     custom_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] duty_red_reg,   duty_red_next;
    logic [7:0] duty_green_reg, duty_green_next;
    logic [7:0] duty_blue_reg,  duty_blue_next;

    logic                     is_tick;
    logic                     fire;
    logic [PHASE_BITS-1:0]    phase_adv;
    logic [IDX_BITS-1:0]      tab_idx;
    logic [8:0]               factor_tab [SINE_TABLE_DEPTH];
    logic [8:0]               factor;
    color_t                   color_sel;
    logic                     blink_due;
    logic [31:0]              blink_half;
    logic [16:0]              prod_r, prod_g, prod_b;

    // Breathing factor table, folded to constants
    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++)
    begin : g_tab
        assign factor_tab[i] = breathe_factor(longint'(i), IDX_BITS);
    end

    // Handshake: the stage holds a tick only while the duty register is full and stalled
    assign is_tick  = (req_reg == REQ_TICK);
    assign fire     = in_valid_reg && (!is_tick || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg      <= req_type;
            now_reg      <= now_ms;
            mode_in_reg  <= mode;
            color_in_reg <= '{red: red, green: green, blue: blue};
        end
    end

    // Phase step and table index
    always_comb
    begin
        phase_adv = phase_reg;
        if (mode_reg == MODE_IDLE)
        begin
            phase_adv = phase_reg + STEP_IDLE;
        end
        else if (mode_reg == MODE_BRAIN_OFFLINE)
        begin
            phase_adv = phase_reg + STEP_AMBER;
        end
    end

    // Table index is the top bits of the advanced phase
    assign tab_idx = phase_adv[PHASE_BITS-1 -: IDX_BITS];

    // Blink timing
    assign blink_half = (mode_reg == MODE_ERROR) ? HALF_ERROR_MS : HALF_BATTERY_MS;
    assign blink_due  = (now_reg - last_toggle_reg) > blink_half;

    // Pattern select: color and factor
    always_comb
    begin
        color_sel = COLOR_OFF;
        factor    = FACTOR_ONE;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                color_sel = COLOR_IDLE;
                factor    = factor_tab[tab_idx];
            end
            MODE_MOVING:        color_sel = COLOR_MOVING;
            MODE_ERROR:         color_sel = (blink_on_reg ^ blink_due) ? COLOR_ERROR : COLOR_OFF;
            MODE_BRAIN_OFFLINE:
            begin
                color_sel = COLOR_AMBER;
                factor    = factor_tab[tab_idx];
            end
            MODE_LOW_BATTERY:   color_sel = (blink_on_reg ^ blink_due) ? COLOR_BATTERY : COLOR_OFF;
            MODE_CUSTOM:        color_sel = custom_reg;
            default:            color_sel = COLOR_OFF;
        endcase
    end

    // Channel scaling
    assign prod_r = {9'd0, color_sel.red}   * {8'd0, factor};
    assign prod_g = {9'd0, color_sel.green} * {8'd0, factor};
    assign prod_b = {9'd0, color_sel.blue}  * {8'd0, factor};

    // State update and duty register load
    always_comb
    begin
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        blink_on_next    = blink_on_reg;
        last_toggle_next = last_toggle_reg;
        custom_next      = custom_reg;
        out_valid_next   = out_valid_reg && out_stall;
        duty_red_next    = duty_red_reg;
        duty_green_next  = duty_green_reg;
        duty_blue_next   = duty_blue_reg;
        if (fire)
        begin
            unique case (req_reg)
                REQ_TICK:
                begin
                    phase_next      = phase_adv;
                    if ((mode_reg == MODE_ERROR || mode_reg == MODE_LOW_BATTERY) && blink_due)
                    begin
                        blink_on_next    = !blink_on_reg;
                        last_toggle_next = now_reg;
                    end
                    out_valid_next  = 1'b1;
                    duty_red_next   = ~prod_r[15:8];
                    duty_green_next = ~prod_g[15:8];
                    duty_blue_next  = ~prod_b[15:8];
                end
                REQ_SET_MODE:
                begin
                    mode_next     = mode_in_reg;
                    phase_next    = '0;
                    blink_on_next = 1'b0;
                end
                REQ_SET_CUSTOM:
                begin
                    mode_next   = MODE_CUSTOM;
                    custom_next = color_in_reg;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            phase_reg       <= '0;
            blink_on_reg    <= 1'b0;
            last_toggle_reg <= '0;
            custom_reg      <= COLOR_OFF;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            blink_on_reg    <= blink_on_next;
            last_toggle_reg <= last_toggle_next;
            custom_reg      <= custom_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        duty_red_reg   <= duty_red_next;
        duty_green_reg <= duty_green_next;
        duty_blue_reg  <= duty_blue_next;
    end

    assign out_valid  = out_valid_reg;
    assign duty_red   = duty_red_reg;
    assign duty_green = duty_green_reg;
    assign duty_blue  = duty_blue_reg;

    // Checks
    a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire && is_tick))
        else $error("output word appeared without a tick");

    a_set_mode_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_reg == REQ_SET_MODE) |=> (!blink_on_reg && phase_reg == '0))
        else $error("set mode did not clear phase and blink");

    a_custom_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_reg == REQ_SET_CUSTOM) |=> (mode_reg == MODE_CUSTOM))
        else $error("set custom did not select custom mode");

    a_stall_holds_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && is_tick && out_valid_reg))
        else $error("input stalled without a blocked tick");

endmodule

`default_nettype wire

/* tb/tb_status_led_pattern_generator_top.sv */
`timescale 1ns / 1ps

module tb_status_led_pattern_generator_top;
    import sled_pkg::*;

    localparam int PH_BITS   = PHASE_BITS_DEF;
    localparam int TBL_DEPTH = SINE_TABLE_DEPTH_DEF;
    localparam int RAND_WORDS = 1900;
    localparam int CYCLE_LIMIT = 1000000;

    // Request and mode codes outside the package enums
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [2:0] MODE_UNDEF6 = 3'd6;
    localparam logic [2:0] MODE_UNDEF7 = 3'd7;

    // Per-tick phase steps, rounded half up to PH_BITS
    localparam longint STEP_IDLE  = (STEP_IDLE_Q32 + (64'd1 << (31 - PH_BITS))) >> (32 - PH_BITS);
    localparam longint STEP_AMBER =
        (STEP_AMBER_Q32 + (64'd1 << (31 - PH_BITS))) >> (32 - PH_BITS);

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] now;
        logic [2:0]  mode;
        color_t      col;
    } led_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [31:0] now_ms = '0;
    logic [2:0]  mode = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  duty_red;
    logic [7:0]  duty_green;
    logic [7:0]  duty_blue;

    status_led_pattern_generator_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .now_ms     (now_ms),
        .mode       (mode),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .duty_red   (duty_red),
        .duty_green (duty_green),
        .duty_blue  (duty_blue)
    );

    always #5 clk = ~clk;

    led_word_t word_queue[$];
    color_t    duty_expect[$];
    led_word_t cur_word;
    int        words_total = 0;
    int        words_taken = 0;
    int        real_words = 0;
    int        fail_count = 0;
    int        cycle_count = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    bit        send_quiet = 1'b0;
    bit        recv_quiet = 1'b0;

    // Predicted LED state
    logic [2:0]         led_mode = MODE_IDLE;
    logic [PH_BITS-1:0] led_phase = '0;
    logic               led_blink = 1'b0;
    logic [31:0]        led_last = '0;
    color_t             led_custom = COLOR_OFF;

    // Q0.8 brightness for a phase: table index, quarter-wave sine, offset to 0..256
    function automatic logic [8:0] breath_gain(input logic [PH_BITS-1:0] ph);
        longint idx, ang, quad, frac, z, z2, inner, outer, s, v;
        idx   = (longint'(ph) * TBL_DEPTH) >> PH_BITS;
        ang   = ((idx << 16) / TBL_DEPTH) & 64'hFFFF;
        quad  = ang >> 14;
        frac  = ang & 64'h3FFF;
        z     = (quad % 2 == 1) ? 16384 - frac : frac;
        z2    = (z * z) >> 14;
        inner = SIN_B - ((z2 * SIN_C) >> 14);
        outer = SIN_A - ((z2 * inner) >> 14);
        s     = (z * outer) >> 14;
        if (s > 16384) s = 16384;
        if (s < 0) s = 0;
        v = (quad >= 2) ? 16384 - s : 16384 + s;
        return 9'((v + 64) >> 7);
    endfunction

    // Common-anode duty: 255 minus each channel
    function automatic color_t anode_duty(input color_t c);
        color_t d;
        d.red   = 8'd255 - c.red;
        d.green = 8'd255 - c.green;
        d.blue  = 8'd255 - c.blue;
        return d;
    endfunction

    function automatic color_t breathe_word(input color_t c, input longint step);
        logic [8:0] g;
        color_t     lvl;
        led_phase = led_phase + PH_BITS'(step);
        g = breath_gain(led_phase);
        lvl.red   = 8'((int'(c.red) * int'(g)) >> 8);
        lvl.green = 8'((int'(c.green) * int'(g)) >> 8);
        lvl.blue  = 8'((int'(c.blue) * int'(g)) >> 8);
        return anode_duty(lvl);
    endfunction

    // Toggle once the wrapped elapsed time exceeds half the period
    function automatic color_t blink_word(input logic [31:0] now, input color_t c,
                                          input logic [31:0] half);
        logic [31:0] elapsed;
        elapsed = now - led_last;
        if (elapsed > half)
        begin
            led_blink = ~led_blink;
            led_last  = now;
        end
        return anode_duty(led_blink ? c : COLOR_OFF);
    endfunction

    // Apply one accepted word; a tick queues one duty word
    task automatic led_predict(input led_word_t w);
        color_t d;
        if (w.req == REQ_SET_MODE)
        begin
            led_mode  = w.mode;
            led_phase = '0;
            led_blink = 1'b0;
        end
        else if (w.req == REQ_SET_CUSTOM)
        begin
            led_mode   = MODE_CUSTOM;
            led_custom = w.col;
        end
        else if (w.req == REQ_TICK)
        begin
            case (led_mode)
                MODE_IDLE:          d = breathe_word(COLOR_IDLE, STEP_IDLE);
                MODE_MOVING:        d = anode_duty(COLOR_MOVING);
                MODE_ERROR:         d = blink_word(w.now, COLOR_ERROR, HALF_ERROR_MS);
                MODE_BRAIN_OFFLINE: d = breathe_word(COLOR_AMBER, STEP_AMBER);
                MODE_LOW_BATTERY:   d = blink_word(w.now, COLOR_BATTERY, HALF_BATTERY_MS);
                MODE_CUSTOM:        d = anode_duty(led_custom);
                default:            d = anode_duty(COLOR_OFF);
            endcase
            duty_expect.push_back(d);
        end
    endtask

    task automatic add_word(input logic [1:0] req, input logic [31:0] now,
                            input logic [2:0] m, input color_t c);
        led_word_t w;
        w.req  = req;
        w.now  = now;
        w.mode = m;
        w.col  = c;
        word_queue.push_back(w);
        words_total++;
        if (req != REQ_UNUSED) real_words++;
    endtask

    task automatic add_tick(input logic [31:0] now);
        add_word(REQ_TICK, now, 3'($urandom), 24'($urandom));
    endtask

    task automatic add_mode(input logic [2:0] m);
        add_word(REQ_SET_MODE, $urandom, m, 24'($urandom));
    endtask

    // Sender gaps: mostly none or short, a few long, with quiet stretches
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 149) == 0) send_quiet = ~send_quiet;
        if (send_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Driver: present the next word once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                led_predict(cur_word);
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_queue.size() > 0)
                begin
                    cur_word = word_queue.pop_front();
                    req_type <= cur_word.req;
                    now_ms   <= cur_word.now;
                    mode     <= cur_word.mode;
                    red      <= cur_word.col.red;
                    green    <= cur_word.col.green;
                    blue     <= cur_word.col.blue;
                    in_valid <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken duty word, then pick the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (duty_expect.size() == 0)
                begin
                    $error("unexpected duty word %0d/%0d/%0d", duty_red, duty_green, duty_blue);
                    fail_count++;
                end
                else
                begin
                    color_t e;
                    e = duty_expect.pop_front();
                    if (duty_red !== e.red)
                    begin
                        $error("duty_red expected %0d got %0d", e.red, duty_red);
                        fail_count++;
                    end
                    if (duty_green !== e.green)
                    begin
                        $error("duty_green expected %0d got %0d", e.green, duty_green);
                        fail_count++;
                    end
                    if (duty_blue !== e.blue)
                    begin
                        $error("duty_blue expected %0d got %0d", e.blue, duty_blue);
                        fail_count++;
                    end
                end
            end
            if ($urandom_range(0, 149) == 0) recv_quiet = ~recv_quiet;
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (recv_quiet || $urandom_range(0, 99) < 60)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 50)
                                                         : $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int          r;
        int          k;
        int          run;
        logic [2:0]  m;
        logic [31:0] clock_ms;

        // Directed: reset state, every mode, blink thresholds and wrap, extremes
        add_tick(32'd0);
        add_tick(32'hFFFF_FFFF);
        add_word(REQ_UNUSED, 32'hFFFF_FFFF, MODE_UNDEF7, 24'hFFFFFF);
        add_mode(MODE_MOVING);
        add_tick(32'd5);
        add_mode(MODE_ERROR);
        add_tick(32'd250);
        add_tick(32'd251);
        add_tick(32'd0);
        add_mode(MODE_LOW_BATTERY);
        add_tick(32'd1000);
        add_tick(32'd1001);
        add_mode(MODE_BRAIN_OFFLINE);
        add_tick(32'd7);
        add_tick(32'd8);
        add_word(REQ_SET_CUSTOM, $urandom, 3'($urandom), 24'hFFFFFF);
        add_tick(32'd9);
        add_word(REQ_SET_CUSTOM, $urandom, 3'($urandom), 24'h000000);
        add_tick(32'd10);
        add_mode(MODE_UNDEF6);
        add_tick(32'd11);
        add_mode(MODE_UNDEF7);
        add_tick(32'd12);
        add_mode(MODE_CUSTOM);
        add_tick(32'd13);
        add_mode(MODE_IDLE);
        add_tick(32'd14);

        // Random: runs of ticks, most after a mode or color change, plus noise
        clock_ms = $urandom;
        while (real_words < RAND_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                add_word(2'($urandom), $urandom, 3'($urandom), 24'($urandom));
            end
            else
            begin
                if (r < 60)
                begin
                    k = $urandom_range(0, 19);
                    m = (k < 18) ? 3'(k % 6) : 3'(6 + k % 2);
                    add_mode(m);
                end
                else if (r < 80)
                begin
                    add_word(REQ_SET_CUSTOM, $urandom, 3'($urandom), 24'($urandom));
                end
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 450)
                                                   : $urandom_range(1, 30);
                repeat (run)
                begin
                    if ($urandom_range(0, 49) == 0)
                        clock_ms = $urandom;
                    else
                        clock_ms = clock_ms + $urandom_range(0, 400);
                    add_tick(clock_ms);
                end
            end
        end

        // Reset, then wait for all words to be taken and all duties checked
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (words_taken == words_total);
        wait (duty_expect.size() == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
